[rtl/qrr_pkg.sv]
// ----------------------------------------------------------------------------
// qrr_pkg
// Shared types, widths and register codes of the reprojection residual block.
// ----------------------------------------------------------------------------
`default_nettype none

package qrr_pkg;

   // configuration register indexes (word address bits [3:2])
   typedef enum logic [1:0] {
      REG_FOCAL  = 2'd0,
      REG_PRIN_X = 2'd1,
      REG_PRIN_Y = 2'd2,
      REG_SCALE  = 2'd3
   } reg_idx_type;

   localparam int CsrAddrW = 4;

   localparam logic [31:0] FocalReset = 32'd32768000;
   localparam logic [31:0] PrinReset  = 32'd0;
   localparam logic [31:0] ScaleReset = 32'd65536;

   // rotation divider: |m| * 2^30 / n
   localparam int RotNumW = 33;
   localparam int RotSh   = 30;
   localparam int RotQW   = 31;
   localparam logic [RotQW-1:0] RotLimit = 31'h4000_0000;

   // camera space coordinates
   localparam int CamW    = 35;
   localparam int CamMagW = 34;

   // projection divider: |c| * 2^16 / |c_z|
   localparam int PrjSh = 16;
   localparam int PrjQW = 32;

   typedef struct packed {
      logic signed [31:0] quat_w;
      logic signed [31:0] quat_x;
      logic signed [31:0] quat_y;
      logic signed [31:0] quat_z;
      logic signed [31:0] trans_x;
      logic signed [31:0] trans_y;
      logic signed [31:0] trans_z;
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic signed [31:0] point_z;
      logic signed [31:0] obs_x;
      logic signed [31:0] obs_y;
   } req_item_type;

   typedef struct packed {
      logic signed [31:0] residual_x;
      logic signed [31:0] residual_y;
      logic               valid_res;
   } rsp_item_type;

   typedef struct packed {
      logic [31:0]        focal;
      logic signed [31:0] prin_x;
      logic signed [31:0] prin_y;
      logic [31:0]        scale;
   } cfg_type;

   typedef struct packed {
      logic signed [CamW-1:0] cam_x;
      logic signed [CamW-1:0] cam_y;
      logic signed [CamW-1:0] cam_z;
      logic signed [31:0]     obs_x;
      logic signed [31:0]     obs_y;
      logic                   nz;
   } cam_type;

endpackage

`default_nettype wire

[rtl/quaternion_reprojection_residual.sv]
// ----------------------------------------------------------------------------
// quaternion_reprojection_residual
// Scaled pinhole reprojection residual with a quaternion camera pose.
// Throughput: one word per cycle while the output word is not held; the two
// long division pipelines (31 and 32 quotient bits, one bit per stage) set
// the depth.
// Reset: synchronous; clears all valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module quaternion_reprojection_residual (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  qrr_pkg::req_item_type           req_item,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output qrr_pkg::rsp_item_type           rsp_item,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [qrr_pkg::CsrAddrW-1:0]    csr_paddr,
   input  logic [31:0]                     csr_pwdata,
   output logic [31:0]                     csr_prdata,
   output logic                            csr_pready
);
   import qrr_pkg::*;

   logic        [31:0] focal_ff, scale_ff;
   logic signed [31:0] prin_x_ff, prin_y_ff;
   logic               csr_wr;
   reg_idx_type        csr_idx;
   cfg_type            cfg;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = reg_idx_type'(csr_paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         focal_ff  <= FocalReset;
         prin_x_ff <= PrinReset;
         prin_y_ff <= PrinReset;
         scale_ff  <= ScaleReset;
      end else if (csr_wr) begin
         case (csr_idx)
            REG_FOCAL:  focal_ff  <= csr_pwdata;
            REG_PRIN_X: prin_x_ff <= csr_pwdata;
            REG_PRIN_Y: prin_y_ff <= csr_pwdata;
            REG_SCALE:  scale_ff  <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_FOCAL:  csr_prdata = focal_ff;
         REG_PRIN_X: csr_prdata = prin_x_ff;
         REG_PRIN_Y: csr_prdata = prin_y_ff;
         REG_SCALE:  csr_prdata = scale_ff;
         default:    csr_prdata = '0;
      endcase
   end

   assign cfg = '{focal: focal_ff, prin_x: prin_x_ff, prin_y: prin_y_ff, scale: scale_ff};

   // whole pipeline moves unless the output word is held
   logic en;
   assign en        = !(rsp_valid && rsp_stall);
   assign req_stall = !en;

   logic    cam_valid;
   cam_type cam;

   qrr_pose u_pose (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .in_item   (req_item),
      .out_valid (cam_valid),
      .out_cam   (cam)
   );

   qrr_proj u_proj (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .cfg       (cfg),
      .in_valid  (cam_valid),
      .in_cam    (cam),
      .out_valid (rsp_valid),
      .out_item  (rsp_item)
   );

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_item.valid_res) |->
         (rsp_item.residual_x == '0 && rsp_item.residual_y == '0))
      else $error("invalid result carries nonzero residuals");

   a_zero_scale: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.valid_res && scale_ff == '0) |->
         (rsp_item.residual_x == '0 && rsp_item.residual_y == '0))
      else $error("zero scale gave nonzero residual");

   a_focal_write: assert property (@(posedge clock) disable iff (reset)
      (csr_wr && csr_idx == REG_FOCAL) |=> (focal_ff == $past(csr_pwdata)))
      else $error("focal register write lost");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |-> req_stall)
      else $error("input taken while output word held");

endmodule

`default_nettype wire

[rtl/qrr_dly.sv]
// ----------------------------------------------------------------------------
// qrr_dly
// Fixed-depth delay line carrying a valid bit and side data.
// ----------------------------------------------------------------------------
`default_nettype none

module qrr_dly #(
   parameter int W     = 1,
   parameter int DEPTH = 1
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         en,
   input  logic         in_valid,
   input  logic [W-1:0] in_data,
   output logic         out_valid,
   output logic [W-1:0] out_data
);

   logic [DEPTH-1:0] vld_ff;
   logic [W-1:0]     dat_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff[0] <= in_valid;
         for (int i = 1; i < DEPTH; i++) begin
            vld_ff[i] <= vld_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dat_ff[0] <= in_data;
         for (int i = 1; i < DEPTH; i++) begin
            dat_ff[i] <= dat_ff[i-1];
         end
      end
   end

   assign out_valid = vld_ff[DEPTH-1];
   assign out_data  = dat_ff[DEPTH-1];

endmodule

`default_nettype wire

[rtl/qrr_div.sv]
// ----------------------------------------------------------------------------
// qrr_div
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
// ----------------------------------------------------------------------------
`default_nettype none

module qrr_div #(
   parameter int NUM_W = 33,
   parameter int DEN_W = 33,
   parameter int SH    = 30,
   parameter int QW    = 31
) (
   input  logic             clock,
   input  logic             en,
   input  logic [NUM_W-1:0] in_num,
   input  logic [DEN_W-1:0] in_den,
   input  logic             in_neg,
   output logic [QW-1:0]    out_quo,
   output logic             out_ovf,
   output logic             out_neg
);

   localparam int DW = NUM_W + SH;
   localparam int BW = DEN_W + QW;
   localparam int CW = (DW > BW) ? DW : BW;

   logic [CW-1:0]    rem_ff [QW+1];
   logic [DEN_W-1:0] den_ff [QW+1];
   logic [QW-1:0]    quo_ff [QW+1];
   logic [QW:0]      ovf_ff;
   logic [QW:0]      neg_ff;

   logic [CW-1:0] dividend;
   logic [CW-1:0] bound;
   logic [CW-1:0] dsh [QW];
   logic [QW-1:0] fit;

   assign dividend = CW'({in_num, {SH{1'b0}}});
   assign bound    = CW'({in_den, {QW{1'b0}}});

   always_comb begin
      for (int s = 0; s < QW; s++) begin
         dsh[s] = CW'(den_ff[s]) << (QW - 1 - s);
         fit[s] = rem_ff[s] >= dsh[s];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= dividend;
         den_ff[0] <= in_den;
         quo_ff[0] <= '0;
         ovf_ff[0] <= dividend >= bound;
         neg_ff[0] <= in_neg;
         for (int s = 0; s < QW; s++) begin
            rem_ff[s+1] <= fit[s] ? rem_ff[s] - dsh[s] : rem_ff[s];
            den_ff[s+1] <= den_ff[s];
            quo_ff[s+1] <= quo_ff[s] | (fit[s] ? (QW'(1) << (QW - 1 - s)) : '0);
            ovf_ff[s+1] <= ovf_ff[s];
            neg_ff[s+1] <= neg_ff[s];
         end
      end
   end

   assign out_quo = quo_ff[QW];
   assign out_ovf = ovf_ff[QW];
   assign out_neg = neg_ff[QW];

endmodule

`default_nettype wire

[rtl/qrr_pose.sv]
// ----------------------------------------------------------------------------
// qrr_pose
// Quaternion products, normalized rotation matrix and camera space point.
// ----------------------------------------------------------------------------
`default_nettype none

module qrr_pose (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  qrr_pkg::req_item_type in_item,
   output logic                  out_valid,
   output qrr_pkg::cam_type      out_cam
);
   import qrr_pkg::*;

   typedef struct packed {
      logic signed [31:0] trans_x;
      logic signed [31:0] trans_y;
      logic signed [31:0] trans_z;
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic signed [31:0] point_z;
      logic signed [31:0] obs_x;
      logic signed [31:0] obs_y;
      logic               nz;
   } pose_side_type;

   function automatic logic signed [31:0] fmul(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
      logic signed [63:0] p;
      p = 64'(a) * 64'(b);
      return p[63:32];
   endfunction

   // stage 1: floored quaternion products
   logic               v1_ff;
   req_item_type       it1_ff;
   logic signed [31:0] ww_ff, xx_ff, yy_ff, zz_ff;
   logic signed [31:0] wx_ff, wy_ff, wz_ff, xy_ff, xz_ff, yz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         it1_ff <= in_item;
         ww_ff  <= fmul(in_item.quat_w, in_item.quat_w);
         xx_ff  <= fmul(in_item.quat_x, in_item.quat_x);
         yy_ff  <= fmul(in_item.quat_y, in_item.quat_y);
         zz_ff  <= fmul(in_item.quat_z, in_item.quat_z);
         wx_ff  <= fmul(in_item.quat_w, in_item.quat_x);
         wy_ff  <= fmul(in_item.quat_w, in_item.quat_y);
         wz_ff  <= fmul(in_item.quat_w, in_item.quat_z);
         xy_ff  <= fmul(in_item.quat_x, in_item.quat_y);
         xz_ff  <= fmul(in_item.quat_x, in_item.quat_z);
         yz_ff  <= fmul(in_item.quat_y, in_item.quat_z);
      end
   end

   // stage 2: norm and unnormalized matrix, split into magnitude and sign
   logic [RotNumW-1:0]   n_in;
   logic signed [33:0]   m_in [9];
   logic signed [33:0]   m_abs [9];
   logic [RotNumW-1:0]   mag_in [9];
   logic [8:0]           sgn_in;

   always_comb begin
      n_in = RotNumW'(ww_ff[30:0]) + RotNumW'(xx_ff[30:0])
           + RotNumW'(yy_ff[30:0]) + RotNumW'(zz_ff[30:0]);
      m_in[0] = 34'(ww_ff) + 34'(xx_ff) - 34'(yy_ff) - 34'(zz_ff);
      m_in[1] = (34'(xy_ff) - 34'(wz_ff)) <<< 1;
      m_in[2] = (34'(wy_ff) + 34'(xz_ff)) <<< 1;
      m_in[3] = (34'(wz_ff) + 34'(xy_ff)) <<< 1;
      m_in[4] = 34'(ww_ff) - 34'(xx_ff) + 34'(yy_ff) - 34'(zz_ff);
      m_in[5] = (34'(yz_ff) - 34'(wx_ff)) <<< 1;
      m_in[6] = (34'(xz_ff) - 34'(wy_ff)) <<< 1;
      m_in[7] = (34'(wx_ff) + 34'(yz_ff)) <<< 1;
      m_in[8] = 34'(ww_ff) - 34'(xx_ff) - 34'(yy_ff) + 34'(zz_ff);
      for (int i = 0; i < 9; i++) begin
         m_abs[i]  = m_in[i][33] ? -m_in[i] : m_in[i];
         mag_in[i] = m_abs[i][RotNumW-1:0];
         sgn_in[i] = m_in[i][33];
      end
   end

   logic               v2_ff;
   logic [RotNumW-1:0] n_ff;
   logic [RotNumW-1:0] mag_ff [9];
   logic [8:0]         sgn_ff;
   pose_side_type      side2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         n_ff   <= n_in;
         mag_ff <= mag_in;
         sgn_ff <= sgn_in;
         side2_ff <= '{trans_x: it1_ff.trans_x, trans_y: it1_ff.trans_y,
                       trans_z: it1_ff.trans_z, point_x: it1_ff.point_x,
                       point_y: it1_ff.point_y, point_z: it1_ff.point_z,
                       obs_x: it1_ff.obs_x, obs_y: it1_ff.obs_y,
                       nz: n_in != '0};
      end
   end

   // nine matrix entries divided by the norm
   logic [RotQW-1:0] dq [9];
   logic [8:0]       dovf;
   logic [8:0]       dneg;

   for (genvar i = 0; i < 9; i++) begin : g_rdiv
      qrr_div #(
         .NUM_W (RotNumW),
         .DEN_W (RotNumW),
         .SH    (RotSh),
         .QW    (RotQW)
      ) u_div (
         .clock   (clock),
         .en      (en),
         .in_num  (mag_ff[i]),
         .in_den  (n_ff),
         .in_neg  (sgn_ff[i]),
         .out_quo (dq[i]),
         .out_ovf (dovf[i]),
         .out_neg (dneg[i])
      );
   end

   logic          vd;
   pose_side_type sided;

   qrr_dly #(
      .W     ($bits(pose_side_type)),
      .DEPTH (RotQW + 1)
   ) u_dly (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v2_ff),
      .in_data   (side2_ff),
      .out_valid (vd),
      .out_data  (sided)
   );

   // stage 3: clamp to +-1.0 and apply the sign
   logic [RotQW-1:0]   rmag [9];
   logic signed [31:0] rot_in [9];

   always_comb begin
      for (int i = 0; i < 9; i++) begin
         rmag[i]   = (dovf[i] || dq[i] > RotLimit) ? RotLimit : dq[i];
         rot_in[i] = dneg[i] ? -32'(rmag[i]) : 32'(rmag[i]);
      end
   end

   logic               v3_ff;
   logic signed [31:0] r_ff [9];
   pose_side_type      side3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (en) begin
         v3_ff <= vd;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         r_ff     <= rot_in;
         side3_ff <= sided;
      end
   end

   // stage 4: matrix times point
   logic signed [31:0] pt [3];
   logic signed [63:0] pr_in [9];

   always_comb begin
      pt[0] = side3_ff.point_x;
      pt[1] = side3_ff.point_y;
      pt[2] = side3_ff.point_z;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            pr_in[i*3+j] = 64'(r_ff[i*3+j]) * 64'(pt[j]);
         end
      end
   end

   logic               v4_ff;
   logic signed [63:0] pr_ff [9];
   pose_side_type      side4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (en) begin
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pr_ff    <= pr_in;
         side4_ff <= side3_ff;
      end
   end

   // stage 5: row sums, back to Q16.16 and translation
   logic signed [65:0]     acc [3];
   logic signed [65:0]     accs [3];
   logic signed [31:0]     tr [3];
   logic signed [CamW-1:0] cam_in [3];

   always_comb begin
      tr[0] = side4_ff.trans_x;
      tr[1] = side4_ff.trans_y;
      tr[2] = side4_ff.trans_z;
      for (int i = 0; i < 3; i++) begin
         acc[i]    = 66'(pr_ff[i*3]) + 66'(pr_ff[i*3+1]) + 66'(pr_ff[i*3+2]);
         accs[i]   = acc[i] >>> 30;
         cam_in[i] = CamW'(accs[i]) + CamW'(tr[i]);
      end
   end

   logic    v5_ff;
   cam_type cam_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else if (en) begin
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cam_ff <= '{cam_x: cam_in[0], cam_y: cam_in[1], cam_z: cam_in[2],
                     obs_x: side4_ff.obs_x, obs_y: side4_ff.obs_y,
                     nz: side4_ff.nz};
      end
   end

   assign out_valid = v5_ff;
   assign out_cam   = cam_ff;

endmodule

`default_nettype wire

[rtl/qrr_proj.sv]
// ----------------------------------------------------------------------------
// qrr_proj
// Perspective divide, focal scaling, residual scaling and saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module qrr_proj (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  qrr_pkg::cfg_type      cfg,
   input  logic                  in_valid,
   input  qrr_pkg::cam_type      in_cam,
   output logic                  out_valid,
   output qrr_pkg::rsp_item_type out_item
);
   import qrr_pkg::*;

   typedef struct packed {
      logic signed [31:0] obs_x;
      logic signed [31:0] obs_y;
      logic               ok;
   } prj_side_type;

   function automatic logic signed [31:0] clip(input logic [PrjQW-1:0] q,
                                              input logic ovf,
                                              input logic neg);
      logic signed [31:0] r;
      if (neg) begin
         r = (ovf || q > 32'h8000_0000) ? 32'sh8000_0000 : -q;
      end else begin
         r = (ovf || q > 32'h7FFF_FFFF) ? 32'sh7FFF_FFFF : q;
      end
      return r;
   endfunction

   logic signed [CamW-1:0] nx, ny, nz_abs;
   logic [CamMagW-1:0]     ax, ay, az;
   prj_side_type           side_in;

   always_comb begin
      nx     = in_cam.cam_x[CamW-1] ? -in_cam.cam_x : in_cam.cam_x;
      ny     = in_cam.cam_y[CamW-1] ? -in_cam.cam_y : in_cam.cam_y;
      nz_abs = in_cam.cam_z[CamW-1] ? -in_cam.cam_z : in_cam.cam_z;
      ax     = nx[CamMagW-1:0];
      ay     = ny[CamMagW-1:0];
      az     = nz_abs[CamMagW-1:0];
      side_in = '{obs_x: in_cam.obs_x, obs_y: in_cam.obs_y,
                  ok: in_cam.nz && (in_cam.cam_z != '0)};
   end

   logic [PrjQW-1:0] qx, qy;
   logic             ovfx, ovfy, negx, negy;

   qrr_div #(
      .NUM_W (CamMagW),
      .DEN_W (CamMagW),
      .SH    (PrjSh),
      .QW    (PrjQW)
   ) u_divx (
      .clock   (clock),
      .en      (en),
      .in_num  (ax),
      .in_den  (az),
      .in_neg  (in_cam.cam_x[CamW-1] ^ in_cam.cam_z[CamW-1]),
      .out_quo (qx),
      .out_ovf (ovfx),
      .out_neg (negx)
   );

   qrr_div #(
      .NUM_W (CamMagW),
      .DEN_W (CamMagW),
      .SH    (PrjSh),
      .QW    (PrjQW)
   ) u_divy (
      .clock   (clock),
      .en      (en),
      .in_num  (ay),
      .in_den  (az),
      .in_neg  (in_cam.cam_y[CamW-1] ^ in_cam.cam_z[CamW-1]),
      .out_quo (qy),
      .out_ovf (ovfy),
      .out_neg (negy)
   );

   logic         vd;
   prj_side_type sided;

   qrr_dly #(
      .W     ($bits(prj_side_type)),
      .DEPTH (PrjQW + 1)
   ) u_dly (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (in_valid),
      .in_data   (side_in),
      .out_valid (vd),
      .out_data  (sided)
   );

   // ratio, saturated to 32 bits
   logic               vg_ff;
   logic signed [31:0] rx_ff, ry_ff;
   prj_side_type       sg_ff;

   // focal times ratio
   logic               vh_ff;
   logic signed [64:0] fx_ff, fy_ff;
   prj_side_type       sh_ff;

   // prediction minus observation, magnitude split at the binary point
   logic               vi_ff;
   logic [31:0]        mhx_ff, mhy_ff;
   logic [15:0]        mlx_ff, mly_ff;
   logic               negx_ff, negy_ff, bigx_ff, bigy_ff, oki_ff;

   // scale products
   logic               vj_ff;
   logic [63:0]        hix_ff, hiy_ff;
   logic [47:0]        lox_ff, loy_ff;
   logic               negxj_ff, negyj_ff, bigxj_ff, bigyj_ff, okj_ff;

   logic               vk_ff;
   rsp_item_type       item_ff;

   logic signed [64:0] fx_in, fy_in;
   logic signed [50:0] dx, dy, ddx, ddy;
   logic [49:0]        magx, magy;

   always_comb begin
      fx_in = $signed({33'b0, cfg.focal}) * 65'(rx_ff);
      fy_in = $signed({33'b0, cfg.focal}) * 65'(ry_ff);
      dx    = -51'(fx_ff >>> 16) + 51'(cfg.prin_x) - 51'(sh_ff.obs_x);
      dy    = -51'(fy_ff >>> 16) + 51'(cfg.prin_y) - 51'(sh_ff.obs_y);
      ddx   = dx[50] ? -dx : dx;
      ddy   = dy[50] ? -dy : dy;
      magx  = ddx[49:0];
      magy  = ddy[49:0];
   end

   function automatic logic signed [31:0] scale_sat(input logic [63:0] hi,
                                                   input logic [47:0] lo,
                                                   input logic neg,
                                                   input logic big,
                                                   input logic szero);
      logic [32:0] total;
      logic [32:0] limit;
      logic [32:0] mag;
      total = 33'(hi[31:0]) + 33'(lo[47:16]);
      limit = neg ? 33'h0_8000_0000 : 33'h0_7FFF_FFFF;
      if (big || hi[63:32] != '0 || total > limit) begin
         mag = limit;
      end else begin
         mag = total;
      end
      if (szero) begin
         mag = '0;
      end
      return neg ? -mag[31:0] : mag[31:0];
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         vg_ff <= 1'b0;
         vh_ff <= 1'b0;
         vi_ff <= 1'b0;
         vj_ff <= 1'b0;
         vk_ff <= 1'b0;
      end else if (en) begin
         vg_ff <= vd;
         vh_ff <= vg_ff;
         vi_ff <= vh_ff;
         vj_ff <= vi_ff;
         vk_ff <= vj_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rx_ff <= clip(qx, ovfx, negx);
         ry_ff <= clip(qy, ovfy, negy);
         sg_ff <= sided;

         fx_ff <= fx_in;
         fy_ff <= fy_in;
         sh_ff <= sg_ff;

         mhx_ff  <= magx[47:16];
         mhy_ff  <= magy[47:16];
         mlx_ff  <= magx[15:0];
         mly_ff  <= magy[15:0];
         bigx_ff <= |magx[49:48];
         bigy_ff <= |magy[49:48];
         negx_ff <= dx[50];
         negy_ff <= dy[50];
         oki_ff  <= sh_ff.ok;

         hix_ff   <= 64'(mhx_ff) * 64'(cfg.scale);
         hiy_ff   <= 64'(mhy_ff) * 64'(cfg.scale);
         lox_ff   <= 48'(mlx_ff) * 48'(cfg.scale);
         loy_ff   <= 48'(mly_ff) * 48'(cfg.scale);
         negxj_ff <= negx_ff;
         negyj_ff <= negy_ff;
         bigxj_ff <= bigx_ff;
         bigyj_ff <= bigy_ff;
         okj_ff   <= oki_ff;

         if (okj_ff) begin
            item_ff.residual_x <= scale_sat(hix_ff, lox_ff, negxj_ff, bigxj_ff,
                                            cfg.scale == '0);
            item_ff.residual_y <= scale_sat(hiy_ff, loy_ff, negyj_ff, bigyj_ff,
                                            cfg.scale == '0);
            item_ff.valid_res  <= 1'b1;
         end else begin
            item_ff <= '0;
         end
      end
   end

   assign out_valid = vk_ff;
   assign out_item  = item_ff;

endmodule

`default_nettype wire

[test/quaternion_reprojection_residual_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// quaternion_reprojection_residual_tb
// Streams pose, point and observation words through the residual block under
// random idling on both channels, predicts every result word in fixed point
// and compares it field by field. Configuration changes between phases.
// ----------------------------------------------------------------------------
`default_nettype none

module quaternion_reprojection_residual_tb;
   import qrr_pkg::*;

   localparam int Latency = 75;
   localparam longint CycleLimit = 64'd3000000;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_stall;
   req_item_type  req_item = '0;
   logic          rsp_valid;
   logic          rsp_stall = 1'b0;
   rsp_item_type  rsp_item;
   logic          csr_psel = 1'b0;
   logic          csr_penable = 1'b0;
   logic          csr_pwrite = 1'b0;
   logic [CsrAddrW-1:0] csr_paddr = '0;
   logic [31:0]   csr_pwdata = '0;
   logic [31:0]   csr_prdata;
   logic          csr_pready;

   quaternion_reprojection_residual i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_item(req_item),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_item(rsp_item),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   cfg_type       shadow_cfg;
   req_item_type  pending_words[$];
   rsp_item_type  expected_residuals[$];
   int            mismatch_count = 0;
   longint        cycle_count = 0;
   bit            run_done = 1'b0;

   task automatic report(input string msg);
      $display("mismatch: %s", msg);
      mismatch_count++;
   endtask

   function automatic void add_word(input req_item_type it);
      pending_words = {pending_words, it};
   endfunction

   function automatic longint floor_shift(input longint v, input int sh);
      return v >>> sh;
   endfunction

   function automatic longint clip(input longint v, input longint lo, input longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic longint scaled_sat(input longint d, input longint scale);
      bit          neg;
      longint unsigned mag, mh, ml, lim, total;
      neg = d < 0;
      mag = neg ? -d : d;
      mh = mag >> 16;
      ml = mag & 64'hFFFF;
      lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
      if (scale == 0) return 0;
      if (mh >= 64'h1_0000_0000) return neg ? -longint'(lim) : longint'(lim);
      total = mh * scale;
      if (total >= 64'h1_0000_0000) return neg ? -longint'(lim) : longint'(lim);
      total += (ml * scale) >> 16;
      if (total > lim) total = lim;
      return neg ? -longint'(total) : longint'(total);
   endfunction

   function automatic longint pixel_error(input longint num, input longint den,
                                          input longint prin, input longint obs);
      longint ratio, proj;
      ratio = clip((num * 65536) / den, -64'sd2147483648, 64'sd2147483647);
      proj = floor_shift(longint'({32'd0, shadow_cfg.focal}) * ratio, 16);
      return -proj + prin - obs;
   endfunction

   function automatic rsp_item_type predict_residual(input req_item_type it);
      rsp_item_type r;
      longint w, x, y, z, ww, xx, yy, zz, wx, wy, wz, xy, xz, yz, n, acc, rot;
      longint m[3][3];
      longint p[3], t[3], c[3];
      r = '0;
      w = it.quat_w; x = it.quat_x; y = it.quat_y; z = it.quat_z;
      p[0] = it.point_x; p[1] = it.point_y; p[2] = it.point_z;
      t[0] = it.trans_x; t[1] = it.trans_y; t[2] = it.trans_z;
      ww = floor_shift(w * w, 32); xx = floor_shift(x * x, 32);
      yy = floor_shift(y * y, 32); zz = floor_shift(z * z, 32);
      wx = floor_shift(w * x, 32); wy = floor_shift(w * y, 32);
      wz = floor_shift(w * z, 32); xy = floor_shift(x * y, 32);
      xz = floor_shift(x * z, 32); yz = floor_shift(y * z, 32);
      n = ww + xx + yy + zz;
      if (n == 0) return r;
      m[0][0] = ww + xx - yy - zz; m[0][1] = 2 * (xy - wz); m[0][2] = 2 * (wy + xz);
      m[1][0] = 2 * (wz + xy); m[1][1] = ww - xx + yy - zz; m[1][2] = 2 * (yz - wx);
      m[2][0] = 2 * (xz - wy); m[2][1] = 2 * (wx + yz); m[2][2] = ww - xx - yy + zz;
      for (int i = 0; i < 3; i++) begin
         acc = 0;
         for (int j = 0; j < 3; j++) begin
            rot = clip((m[i][j] * (64'sd1 << 30)) / n, -(64'sd1 << 30), 64'sd1 << 30);
            acc += rot * p[j];
         end
         c[i] = floor_shift(acc, 30) + t[i];
      end
      if (c[2] == 0) return r;
      r.residual_x = 32'(scaled_sat(pixel_error(c[0], c[2], shadow_cfg.prin_x, it.obs_x),
                                    shadow_cfg.scale));
      r.residual_y = 32'(scaled_sat(pixel_error(c[1], c[2], shadow_cfg.prin_y, it.obs_y),
                                    shadow_cfg.scale));
      r.valid_res = 1'b1;
      return r;
   endfunction

   // gap length: mostly short, now and then long
   function automatic int idle_len();
      int k;
      k = $urandom_range(0, 99);
      if (k < 55) return 0;
      if (k < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // driver
   int send_gap = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            expected_residuals = {expected_residuals, predict_residual(req_item)};
            send_gap = idle_len();
         end
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_words.size() > 0) begin
               req_item <= pending_words.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   int stall_left = 0;
   always @(posedge clock) begin
      cycle_count++;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_residuals.size() == 0) begin
               report("result word with nothing expected");
            end else begin
               rsp_item_type e;
               e = expected_residuals.pop_front();
               if (rsp_item.residual_x !== e.residual_x)
                  report($sformatf("residual_x got %h want %h", rsp_item.residual_x,
                                   e.residual_x));
               if (rsp_item.residual_y !== e.residual_y)
                  report($sformatf("residual_y got %h want %h", rsp_item.residual_y,
                                   e.residual_y));
               if (rsp_item.valid_res !== e.valid_res)
                  report($sformatf("valid_res got %b want %b", rsp_item.valid_res,
                                   e.valid_res));
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            stall_left = idle_len();
            rsp_stall <= stall_left > 0;
         end
      end
      if (cycle_count > CycleLimit && !run_done) begin
         $display("quaternion_reprojection_residual verification failed");
         $finish;
      end
   end

   task automatic csr_write(input reg_idx_type idx, input logic [31:0] value);
      @(posedge clock);
      csr_psel <= 1'b1; csr_pwrite <= 1'b1; csr_penable <= 1'b0;
      csr_paddr <= CsrAddrW'({idx, 2'b00}); csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      case (idx)
         REG_FOCAL:  shadow_cfg.focal = value;
         REG_PRIN_X: shadow_cfg.prin_x = value;
         REG_PRIN_Y: shadow_cfg.prin_y = value;
         REG_SCALE:  shadow_cfg.scale = value;
         default: ;
      endcase
   endtask

   // sample at the falling edge so that the driver's updates have settled
   task automatic drain();
      while (pending_words.size() > 0 || req_valid || expected_residuals.size() > 0)
         @(negedge clock);
      repeat (Latency + 10) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_word();
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return $urandom_range(0, 255) - 128;
         default: return $urandom;
      endcase
   endfunction

   // unit-ish quaternion, moderate point mostly in front of the camera
   function automatic req_item_type plausible_word();
      req_item_type it;
      it.quat_w = 32'sh4000_0000 + $signed(32'($urandom_range(0, 32'h0FFF_FFFF)))
                  - 32'sh0800_0000;
      it.quat_x = $signed(32'($urandom_range(0, 32'h1FFF_FFFF))) - 32'sh1000_0000;
      it.quat_y = $signed(32'($urandom_range(0, 32'h1FFF_FFFF))) - 32'sh1000_0000;
      it.quat_z = $signed(32'($urandom_range(0, 32'h1FFF_FFFF))) - 32'sh1000_0000;
      it.trans_x = $signed(32'($urandom_range(0, 32'h00FF_FFFF))) - 32'sh0080_0000;
      it.trans_y = $signed(32'($urandom_range(0, 32'h00FF_FFFF))) - 32'sh0080_0000;
      it.trans_z = 32'sh0020_0000 + 32'($urandom_range(0, 32'h00FF_FFFF));
      it.point_x = $signed(32'($urandom_range(0, 32'h00FF_FFFF))) - 32'sh0080_0000;
      it.point_y = $signed(32'($urandom_range(0, 32'h00FF_FFFF))) - 32'sh0080_0000;
      it.point_z = $signed(32'($urandom_range(0, 32'h00FF_FFFF))) - 32'sh0080_0000;
      it.obs_x = $signed(32'($urandom_range(0, 32'h03FF_FFFF))) - 32'sh0200_0000;
      it.obs_y = $signed(32'($urandom_range(0, 32'h03FF_FFFF))) - 32'sh0200_0000;
      return it;
   endfunction

   function automatic req_item_type noise_word();
      req_item_type it;
      it.quat_w = rand_word(); it.quat_x = rand_word();
      it.quat_y = rand_word(); it.quat_z = rand_word();
      it.trans_x = rand_word(); it.trans_y = rand_word(); it.trans_z = rand_word();
      it.point_x = rand_word(); it.point_y = rand_word(); it.point_z = rand_word();
      it.obs_x = rand_word(); it.obs_y = rand_word();
      return it;
   endfunction

   initial begin
      req_item_type it;
      logic [31:0] cfg_sets[4][4];
      shadow_cfg = '{FocalReset, PrinReset, PrinReset, ScaleReset};
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: identity pose, point straight ahead
      it = '0; it.quat_w = 32'sh4000_0000; it.point_z = 32'sh0001_0000;
      add_word(it);
      // zero quaternion
      it = '0; it.point_z = 32'sh0001_0000;
      add_word(it);
      // tiny quaternion: every floored square vanishes
      it.quat_w = 32'sd1; it.quat_x = -32'sd1;
      add_word(it);
      // zero depth from translation canceling the point
      it = '0; it.quat_w = 32'sh4000_0000; it.point_z = 32'sh0002_0000;
      it.trans_z = -32'sh0002_0000; it.point_x = 32'sh0001_0000;
      add_word(it);
      // huge ratio: tiny depth, large lateral offset
      it = '0; it.quat_w = 32'sh4000_0000; it.point_z = 32'sd1;
      it.point_x = 32'sh7FFF_FFFF; it.point_y = 32'sh8000_0000;
      add_word(it);
      // extremes of every field
      it = {12{32'h7FFF_FFFF}}; add_word(it);
      it = {12{32'h8000_0000}}; add_word(it);
      it = {12{32'hFFFF_FFFF}}; add_word(it);
      it = {6{32'h8000_0000, 32'h7FFF_FFFF}}; add_word(it);
      for (int i = 0; i < 10; i++) add_word(noise_word());
      drain();

      cfg_sets[0] = '{32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF};
      cfg_sets[1] = '{32'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'd0};
      cfg_sets[2] = '{32'h0000_8000, 32'h0140_0000, 32'h00F0_0000, 32'h0000_0100};
      cfg_sets[3] = '{FocalReset, PrinReset, PrinReset, ScaleReset};
      for (int ph = 0; ph < 6; ph++) begin
         if (ph < 4) begin
            csr_write(REG_FOCAL, cfg_sets[ph][0]);
            csr_write(REG_PRIN_X, cfg_sets[ph][1]);
            csr_write(REG_PRIN_Y, cfg_sets[ph][2]);
            csr_write(REG_SCALE, cfg_sets[ph][3]);
         end else begin
            csr_write(REG_FOCAL, $urandom);
            csr_write(REG_PRIN_X, $urandom);
            csr_write(REG_PRIN_Y, $urandom);
            csr_write(REG_SCALE, $urandom_range(0, 32'h0004_0000));
         end
         for (int i = 0; i < 330; i++)
            add_word($urandom_range(0, 3) == 0 ? noise_word() : plausible_word());
         drain();
      end

      run_done = 1'b1;
      if (mismatch_count == 0) begin
         $display("quaternion_reprojection_residual verification clean");
      end else begin
         $display("quaternion_reprojection_residual verification failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
